// ===== rtl/core/x86dec_pkg.sv =====
// Package for the byte-serial 8086 instruction decoder.
// Holds operand kinds, attribute bits, decode phases and the length helpers.
// Used by every module in rtl/core.
package x86dec_pkg;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_IMM  = 3'd1,
    K_REG  = 3'd2,
    K_SEG  = 3'd3,
    K_MEM  = 3'd4,
    K_LOC  = 3'd5
  } kind_t;

  localparam logic [7:0] A_BX   = 8'h01;
  localparam logic [7:0] A_BP   = 8'h02;
  localparam logic [7:0] A_SI   = 8'h04;
  localparam logic [7:0] A_DI   = 8'h08;
  localparam logic [7:0] A_DISP = 8'h10;
  localparam logic [7:0] A_SGN  = 8'h20;
  localparam logic [7:0] A_FAR  = 8'h40;
  localparam logic [7:0] A_WIDE = 8'h80;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_MODRM  = 2'd1,
    PH_DISP   = 2'd2,
    PH_IMM    = 2'd3
  } phase_t;

  // Completed instruction bytes handed from the byte collector to the decoder
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  count;
  } insn_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic [7:0]  attrs;
  } opnd_t;

  function automatic logic need_modrm(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c[7:6])
      2'b00: r = !c[2];
      2'b01: r = 1'b0;
      2'b10: r = (c[5:4] == 2'b00);
      default: begin
        case (c[5:4])
          2'b00: r = !c[3] && ((c[2:1] == 2'b00) || c[2]);
          2'b01: r = c[3] || !c[2];
          2'b10: r = 1'b0;
          default: r = (c[2:1] == 2'b11);
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] disp_len(input logic [7:0] c, input logic [7:0] m);
    logic [1:0] r;
    r = 2'd0;
    if (!need_modrm(c)) r = 2'd0;
    else if ((c[7:1] == 7'h7F) && (m[5:3] == 3'd7)) r = 2'd0;
    else if (m[7:6] == 2'd1) r = 2'd1;
    else if (m[7:6] == 2'd2) r = 2'd2;
    else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) r = 2'd2;
    return r;
  endfunction

  function automatic logic [2:0] imm_len(input logic [7:0] c, input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    case (c[7:6])
      2'b00: r = (c[2:1] == 2'b10) ? (c[0] ? 3'd2 : 3'd1) : 3'd0;
      2'b01: r = (c[5:4] == 2'b11) ? 3'd1 : 3'd0;
      2'b10: begin
        case (c[5:4])
          2'b00: r = (c[3:2] == 2'b00) ? ((c[0] && !c[1]) ? 3'd2 : 3'd1) : 3'd0;
          2'b01: r = (c == 8'h9A) ? 3'd4 : 3'd0;
          2'b10: begin
            if (c[3:2] == 2'b00) r = 3'd2;
            else if (c[3:1] == 3'b100) r = c[0] ? 3'd2 : 3'd1;
            else r = 3'd0;
          end
          default: r = c[3] ? 3'd2 : 3'd1;
        endcase
      end
      default: begin
        case (c)
          8'hC0, 8'hC1, 8'hC6, 8'hCD: r = 3'd1;
          8'hC2, 8'hCA, 8'hC7: r = 3'd2;
          8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hEB: r = 3'd1;
          8'hE8, 8'hE9: r = 3'd2;
          8'hEA: r = 3'd4;
          8'hF6, 8'hF7: r = (m[5:4] != 2'b00) ? 3'd0 : (c[0] ? 3'd2 : 3'd1);
          default: r = 3'd0;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/x86dec_collect.sv =====
// Byte collector: gathers opcode, ModRM, displacement and immediate bytes.
// Depends on x86dec_pkg; raises done with the registered instruction record.
module x86dec_collect
  import x86dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       hold,
  input  logic [7:0] code_byte,
  input  logic       resync,
  output logic       done,
  output insn_t      insn
);

  phase_t      phase, phase_next;
  logic [7:0]  opcode, opcode_next;
  logic [7:0]  modrm, modrm_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [15:0] disp, disp_next;
  logic [15:0] imm, imm_next;
  logic [2:0]  count, count_next;
  logic        done_c;

  logic [2:0] start_c, k_c, il_c;
  logic [1:0] dl_c;
  logic [2:0] left_dec;

  always_comb begin
    phase_next = phase;
    opcode_next = opcode;
    modrm_next = modrm;
    bytes_left_next = bytes_left;
    disp_next = disp;
    imm_next = imm;
    count_next = count;
    done_c = 1'b0;
    dl_c = disp_len(opcode, modrm);
    start_c = 3'd1 + {2'b00, need_modrm(opcode)} + {1'b0, dl_c};
    k_c = count - start_c;
    left_dec = (bytes_left != 3'd0) ? bytes_left - 3'd1 : 3'd0;
    il_c = 3'd0;
    if (resync || phase == PH_OPCODE) begin
      opcode_next = code_byte;
      modrm_next = 8'h00;
      disp_next = 16'h0000;
      imm_next = 16'h0000;
      count_next = 3'd1;
      bytes_left_next = 3'd0;
      if (need_modrm(code_byte)) begin
        phase_next = PH_MODRM;
      end else begin
        il_c = imm_len(code_byte, 8'h00);
        if (il_c != 3'd0) begin
          phase_next = PH_IMM;
          bytes_left_next = il_c;
        end else begin
          phase_next = PH_OPCODE;
          done_c = 1'b1;
        end
      end
    end else if (phase == PH_MODRM) begin
      modrm_next = code_byte;
      count_next = count + 3'd1;
      dl_c = disp_len(opcode, code_byte);
      il_c = imm_len(opcode, code_byte);
      if (dl_c != 2'd0) begin
        phase_next = PH_DISP;
        bytes_left_next = {1'b0, dl_c};
      end else if (il_c != 3'd0) begin
        phase_next = PH_IMM;
        bytes_left_next = il_c;
      end else begin
        phase_next = PH_OPCODE;
        done_c = 1'b1;
      end
    end else if (phase == PH_DISP) begin
      if (count[0]) disp_next = disp | {code_byte, 8'h00};
      else disp_next = disp | {8'h00, code_byte};
      count_next = count + 3'd1;
      bytes_left_next = left_dec;
      if (left_dec == 3'd0) begin
        il_c = imm_len(opcode, modrm);
        if (il_c != 3'd0) begin
          phase_next = PH_IMM;
          bytes_left_next = il_c;
        end else begin
          phase_next = PH_OPCODE;
          done_c = 1'b1;
        end
      end
    end else begin
      // low two byte slots fill the offset, the next two the segment word
      case (k_c[1:0])
        2'd0: imm_next = imm | {8'h00, code_byte};
        2'd1: imm_next = imm | {code_byte, 8'h00};
        2'd2: disp_next = disp | {8'h00, code_byte};
        default: disp_next = disp | {code_byte, 8'h00};
      endcase
      count_next = count + 3'd1;
      bytes_left_next = left_dec;
      if (left_dec == 3'd0) begin
        phase_next = PH_OPCODE;
        done_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPCODE;
      opcode <= 8'h00;
      modrm <= 8'h00;
      bytes_left <= 3'd0;
      disp <= 16'h0000;
      imm <= 16'h0000;
      count <= 3'd0;
      done <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        opcode <= opcode_next;
        modrm <= modrm_next;
        bytes_left <= bytes_left_next;
        disp <= disp_next;
        imm <= imm_next;
        count <= count_next;
        done <= done_c;
      end else begin
        // keep a finished record until the output register takes it
        done <= done && hold;
      end
    end
  end

  assign insn.opcode = opcode;
  assign insn.modrm = modrm;
  assign insn.disp = disp;
  assign insn.imm = imm;
  assign insn.count = count;

endmodule

// ===== rtl/core/x86dec_decode.sv =====
// Combinational operand decoder for one collected instruction record.
// Depends on x86dec_pkg.
module x86dec_decode
  import x86dec_pkg::*;
(
  input  insn_t       insn,
  output logic [5:0]  op_group,
  output logic [3:0]  op_index,
  output logic [1:0]  operand_count,
  output opnd_t       dst,
  output opnd_t       src,
  output logic [15:0] far_segment,
  output logic        suspicious_null
);

  function automatic logic [15:0] sext8(input logic [15:0] v);
    return {{8{v[7]}}, v[7:0]};
  endfunction

  function automatic opnd_t mk(input kind_t k, input logic [15:0] v, input logic [7:0] a);
    opnd_t o;
    o.kind = k;
    o.value = v;
    o.attrs = a;
    return o;
  endfunction

  function automatic logic [7:0] base_regs(input logic [2:0] r);
    logic [7:0] a;
    case (r)
      3'd0: a = A_BX | A_SI;
      3'd1: a = A_BX | A_DI;
      3'd2: a = A_BP | A_SI;
      3'd3: a = A_BP | A_DI;
      3'd4: a = A_SI;
      3'd5: a = A_DI;
      3'd6: a = A_BP;
      default: a = A_BX;
    endcase
    return a;
  endfunction

  function automatic opnd_t rm_opnd(input logic w, input logic [7:0] m, input logic [15:0] d);
    logic [7:0] wide;
    logic [7:0] at;
    logic [15:0] v;
    wide = w ? A_WIDE : 8'h00;
    at = base_regs(m[2:0]);
    v = 16'h0000;
    if (m[7:6] == 2'd3) return mk(K_REG, {13'd0, m[2:0]}, wide);
    if (m[7:6] == 2'd0 && m[2:0] == 3'd6) begin
      v = d;
      at = A_DISP;
    end else if (m[7:6] == 2'd1) begin
      v = sext8(d);
      at = at | A_DISP;
    end else if (m[7:6] == 2'd2) begin
      v = d;
      at = at | A_DISP;
    end
    return mk(K_MEM, v, at | wide);
  endfunction

  function automatic opnd_t imm_opnd(input logic w, input logic [15:0] i);
    return w ? mk(K_IMM, i, A_WIDE) : mk(K_IMM, {8'h00, i[7:0]}, 8'h00);
  endfunction

  function automatic opnd_t reg_opnd(input logic w, input logic [2:0] r);
    return mk(K_REG, {13'd0, r}, w ? A_WIDE : 8'h00);
  endfunction

  logic [7:0]  c, m;
  logic [15:0] dsp, imm;
  logic        w2, w1, d;
  logic [2:0]  reg1, reg2;
  logic [1:0]  seg1, seg2;
  opnd_t       a, b, x, y, none_o;

  always_comb begin
    c = insn.opcode;
    m = insn.modrm;
    dsp = insn.disp;
    imm = insn.imm;
    w2 = c[0];
    w1 = c[3];
    d = c[1];
    reg1 = c[2:0];
    seg1 = c[4:3];
    reg2 = m[5:3];
    seg2 = m[4:3];
    none_o = mk(K_NONE, 16'h0000, 8'h00);
    a = none_o;
    b = none_o;
    op_group = 6'd0;
    op_index = 4'd0;
    operand_count = 2'd0;
    far_segment = 16'h0000;
    suspicious_null = 1'b0;
    x = reg_opnd(w2, reg2);
    y = rm_opnd(w2, m, dsp);
    case (c[7:6])
      2'b00: begin
        if (!c[2]) begin
          op_group = 6'd1; op_index = {1'b0, c[5:3]}; operand_count = 2'd2;
          if (d) begin a = x; b = y; end else begin a = y; b = x; end
          suspicious_null = (c[5:3] == 3'd0) && (m == 8'h00);
        end else if (!c[1]) begin
          op_group = 6'd1; op_index = {1'b0, c[5:3]}; operand_count = 2'd2;
          a = reg_opnd(w2, 3'd0); b = imm_opnd(w2, imm);
        end else if (!c[5]) begin
          op_group = 6'd2; op_index = {3'd0, c[0]}; operand_count = 2'd1;
          a = mk(K_SEG, {14'd0, seg1}, A_WIDE);
        end else if (!c[0]) begin
          op_group = 6'd3; operand_count = 2'd1;
          a = mk(K_SEG, {14'd0, seg1}, A_WIDE);
        end else begin
          op_group = 6'd4; op_index = {2'd0, seg1};
        end
      end
      2'b01: begin
        case (c[5:4])
          2'b00: begin
            op_group = 6'd5; op_index = {3'd0, w1}; operand_count = 2'd1;
            a = reg_opnd(1'b1, reg1);
          end
          2'b01: begin
            op_group = 6'd2; op_index = {3'd0, w1}; operand_count = 2'd1;
            a = reg_opnd(1'b1, reg1);
          end
          2'b10: begin
            if (c[3:1] == 3'd0) begin op_group = 6'd6; op_index = {3'd0, w2}; end
          end
          default: begin
            op_group = 6'd7; op_index = c[3:0]; operand_count = 2'd1;
            a = mk(K_LOC, sext8(imm), 8'h00);
          end
        endcase
      end
      2'b10: begin
        case (c[5:4])
          2'b00: begin
            if (!c[2]) begin
              if (!c[3]) begin
                op_group = 6'd1; op_index = {1'b0, reg2}; operand_count = 2'd2;
                a = y;
                if (w2 && d) b = mk(K_IMM, sext8(imm), A_WIDE | A_SGN);
                else b = imm_opnd(w2, imm);
              end else begin
                op_group = 6'd8; operand_count = 2'd2;
                if (d) begin a = x; b = y; end else begin a = y; b = x; end
              end
            end else if (!c[3]) begin
              op_group = c[1] ? 6'd10 : 6'd9; operand_count = 2'd2;
              a = x; b = y;
            end else if (!c[0]) begin
              op_group = 6'd8; operand_count = 2'd2;
              if (d) begin
                a = mk(K_SEG, {14'd0, seg2}, A_WIDE); b = rm_opnd(1'b1, m, dsp);
              end else begin
                a = rm_opnd(1'b1, m, dsp); b = mk(K_SEG, {14'd0, seg2}, A_WIDE);
              end
            end else if (!c[1]) begin
              op_group = 6'd11; operand_count = 2'd2;
              a = reg_opnd(1'b1, reg2); b = rm_opnd(1'b1, m, dsp);
            end else begin
              op_group = 6'd12; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
            end
          end
          2'b01: begin
            if (!c[3]) begin
              if (c == 8'h90) op_group = 6'd13;
              else begin
                op_group = 6'd10; operand_count = 2'd2;
                a = reg_opnd(1'b1, 3'd0); b = reg_opnd(1'b1, reg1);
              end
            end else begin
              case (reg1)
                3'd0, 3'd1: begin op_group = 6'd14; op_index = {3'd0, w2}; end
                3'd2: begin
                  op_group = 6'd15; operand_count = 2'd1;
                  a = mk(K_LOC, imm, A_FAR); far_segment = dsp;
                end
                3'd3: op_group = 6'd16;
                3'd4, 3'd5: begin op_group = 6'd17; op_index = {3'd0, w2}; end
                default: begin op_group = 6'd18; op_index = {3'd0, w2}; end
              endcase
            end
          end
          2'b10: begin
            if (c[3:2] == 2'b00) begin
              op_group = 6'd8; operand_count = 2'd2;
              if (d) begin
                a = mk(K_MEM, imm, A_DISP | (w2 ? A_WIDE : 8'h00));
                b = reg_opnd(w2, 3'd0);
              end else begin
                a = reg_opnd(w2, 3'd0);
                b = mk(K_MEM, imm, A_DISP | (w2 ? A_WIDE : 8'h00));
              end
            end else if (c[3:1] == 3'b100) begin
              op_group = 6'd9; operand_count = 2'd2;
              a = reg_opnd(w2, 3'd0); b = imm_opnd(w2, imm);
            end else begin
              op_group = 6'd19; op_index = {1'b0, c[3:1]};
            end
          end
          default: begin
            op_group = 6'd8; operand_count = 2'd2;
            a = reg_opnd(w1, reg1); b = imm_opnd(w1, imm);
          end
        endcase
      end
      default: begin
        case (c[5:4])
          2'b00: begin
            if (!c[3]) begin
              if (!c[2]) begin
                if (!c[1]) begin
                  op_group = 6'd20; op_index = {1'b0, reg2}; operand_count = 2'd2;
                  a = y; b = imm_opnd(1'b0, imm);
                end else begin
                  op_group = 6'd21;
                  if (!c[0]) begin operand_count = 2'd1; a = imm_opnd(1'b1, imm); end
                end
              end else if (!c[1]) begin
                op_group = 6'd22; op_index = {3'd0, w2}; operand_count = 2'd2;
                a = reg_opnd(1'b1, reg2);
                b = rm_opnd(1'b1, m, dsp);
                b.attrs = b.attrs | A_FAR;
              end else begin
                op_group = 6'd8; operand_count = 2'd2; a = y; b = imm_opnd(w2, imm);
              end
            end else if (!c[2]) begin
              if (c[1]) begin
                op_group = 6'd23;
                if (!c[0]) begin operand_count = 2'd1; a = imm_opnd(1'b1, imm); end
              end
            end else begin
              op_group = 6'd24; op_index = {2'd0, c[1:0]};
              if (c[1:0] == 2'd1) begin operand_count = 2'd1; a = imm_opnd(1'b0, imm); end
            end
          end
          2'b01: begin
            if (!c[3]) begin
              if (!c[2]) begin
                op_group = 6'd20; op_index = {1'b0, reg2}; operand_count = 2'd2;
                a = y;
                b = d ? mk(K_REG, 16'd1, 8'h00) : mk(K_IMM, 16'd1, 8'h00);
              end else begin
                op_group = c[1] ? 6'd26 : 6'd25; op_index = {3'd0, w2};
              end
            end else begin
              op_group = 6'd27; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
            end
          end
          2'b10: begin
            if (!c[2]) begin
              if (!c[3]) begin
                op_group = 6'd28; op_index = {2'd0, c[1:0]}; operand_count = 2'd1;
                a = mk(K_LOC, sext8(imm), 8'h00);
              end else if (!c[1]) begin
                op_group = 6'd29; op_index = {3'd0, w2}; operand_count = 2'd1;
                a = mk(K_LOC, imm, 8'h00);
              end else if (!c[0]) begin
                op_group = 6'd30; operand_count = 2'd1;
                a = mk(K_LOC, imm, A_FAR); far_segment = dsp;
              end else begin
                op_group = 6'd31; operand_count = 2'd1;
                a = mk(K_LOC, sext8(imm), 8'h00);
              end
            end else begin
              op_group = 6'd32; op_index = {3'd0, d}; operand_count = 2'd2;
              if (d) begin
                a = w1 ? reg_opnd(1'b1, 3'd2) : mk(K_IMM, {8'h00, imm[7:0]}, A_WIDE);
                b = reg_opnd(w2, 3'd0);
              end else begin
                a = reg_opnd(w2, 3'd0);
                b = w1 ? reg_opnd(1'b1, 3'd2) : mk(K_IMM, {8'h00, imm[7:0]}, A_WIDE);
              end
            end
          end
          default: begin
            if (!c[3]) begin
              if (c[2:1] != 2'b11) begin
                if (c != 8'hF1) begin op_group = 6'd33; op_index = {1'b0, reg1}; end
              end else if (m[5:4] == 2'b00) begin
                op_group = 6'd9; operand_count = 2'd2; a = y; b = imm_opnd(w2, imm);
              end else begin
                op_group = 6'd34; op_index = {1'b0, reg2}; operand_count = 2'd1; a = y;
              end
            end else if (c[2:1] != 2'b11) begin
              op_group = 6'd35; op_index = {1'b0, reg1};
            end else begin
              case (reg2)
                3'd0, 3'd1: begin
                  op_group = 6'd36; op_index = {1'b0, reg2}; operand_count = 2'd1; a = y;
                end
                3'd2: begin
                  op_group = 6'd37; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
                end
                3'd3: begin
                  op_group = 6'd15; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
                  a.attrs = a.attrs | A_FAR;
                end
                3'd4: begin
                  op_group = 6'd31; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
                end
                3'd5: begin
                  op_group = 6'd30; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
                  a.attrs = a.attrs | A_FAR;
                end
                3'd6: begin
                  op_group = 6'd38; operand_count = 2'd1; a = rm_opnd(1'b1, m, dsp);
                end
                default: op_group = 6'd0;
              endcase
            end
          end
        endcase
      end
    endcase
    dst = a;
    src = b;
  end

endmodule

// ===== rtl/core/x86_16bit_instruction_decoder.sv =====
// Top level of the byte-serial 8086 instruction decoder.
// Depends on x86dec_pkg, x86dec_collect and x86dec_decode.
//
// Usage:
//   Input channel (in_valid/in_stall, code_byte, resync) takes one code
//   byte a cycle while in_stall is low. Set resync with a byte to start a new instruction there;
//   a partial instruction is dropped without a result.
//   Output channel (out_valid/out_stall) presents one decoded instruction
//   per completed instruction: group, index, length and two operands.
//   Prefix bytes come out as one-byte instructions.
// Path: the final byte of an instruction is registered in the collector, then
//   the result word is registered in the output register.
// Throughput: one byte per cycle while in_stall is low, set by the single-pass collector.
// Reset: rst clears the collector to expect an opcode and empties the
//   output register.
// Stall: while out_stall holds a waiting word, bytes keep being collected
//   until the next instruction completes; in_stall then rises until the
//   output register frees up.
module x86_16bit_instruction_decoder
  import x86dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        resync,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  op_group,
  output logic [3:0]  op_index,
  output logic [2:0]  length,
  output logic [1:0]  operand_count,
  output logic [2:0]  dest_kind,
  output logic [15:0] dest_value,
  output logic [7:0]  dest_attrs,
  output logic [2:0]  src_kind,
  output logic [15:0] src_value,
  output logic [7:0]  src_attrs,
  output logic [15:0] far_segment,
  output logic        suspicious_null
);

  logic        take, done, load;
  insn_t       insn;
  logic [5:0]  grp_c;
  logic [3:0]  idx_c;
  logic [1:0]  cnt_c;
  opnd_t       dst_c, src_c;
  logic [15:0] fs_c;
  logic        nul_c;
  logic        out_free;

  // done is a pending word from the collector; it waits while the output holds
  assign out_free = !out_valid || !out_stall;
  assign load = done && out_free;
  assign in_stall = done && !out_free;
  assign take = in_valid && !in_stall;

  x86dec_collect u_collect (
    .clk(clk), .rst(rst), .take(take), .hold(in_stall), .code_byte(code_byte),
    .resync(resync), .done(done), .insn(insn)
  );

  x86dec_decode u_decode (
    .insn(insn), .op_group(grp_c), .op_index(idx_c), .operand_count(cnt_c),
    .dst(dst_c), .src(src_c), .far_segment(fs_c), .suspicious_null(nul_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_group <= grp_c;
      op_index <= idx_c;
      length <= insn.count;
      operand_count <= cnt_c;
      dest_kind <= dst_c.kind;
      dest_value <= dst_c.value;
      dest_attrs <= dst_c.attrs;
      src_kind <= src_c.kind;
      src_value <= src_c.value;
      src_attrs <= src_c.attrs;
      far_segment <= fs_c;
      suspicious_null <= nul_c;
    end
  end

endmodule

// ===== rtl/core/x86dec_checker.sv =====
// Port-level checker for the instruction decoder, bound to the top level.
// Depends on x86dec_pkg.
module x86dec_checker
  import x86dec_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] op_group,
  input logic [2:0] length,
  input logic [1:0] operand_count,
  input logic [2:0] src_kind
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(op_group))
    else $error("stalled word changed");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length != 3'd0 && length <= 3'd6)
    else $error("bad length");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && operand_count < 2'd2 |-> src_kind == 3'd0)
    else $error("src operand beyond count");

  a_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_group == 6'd0 |-> operand_count == 2'd0)
    else $error("invalid opcode with operands");

endmodule

bind x86_16bit_instruction_decoder x86dec_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .op_group(op_group), .length(length), .operand_count(operand_count),
  .src_kind(src_kind)
);

// ===== tb/tb_x86_16bit_instruction_decoder.sv =====
// Self-checking testbench for the byte-serial 8086 instruction decoder.
// Holds its own decode predictor; needs x86dec_pkg and the decoder top level.
module tb_x86_16bit_instruction_decoder;
  import x86dec_pkg::*;

  typedef enum logic [5:0] {
    G_INVALID, G_CALC2, G_STACK1, G_SEG, G_ADJUST1, G_STEP, G_STACK2, G_JCC,
    G_MOV, G_TEST, G_XCHG, G_LEA, G_POP, G_NOP, G_CONVERT, G_CALLF, G_WAIT,
    G_STACK3, G_FLAGS1, G_STRING, G_BITS, G_RET, G_LOAD, G_RETF, G_INTS,
    G_ADJUST2, G_MISC, G_ESC, G_LOOP, G_FLOW, G_JMPF, G_JMP, G_PORT, G_PREFIX,
    G_CALC1, G_FLAGS2, G_INC, G_CALL, G_PUSH
  } grp_t;

  typedef struct {
    grp_t        grp;
    logic [3:0]  idx;
    logic [2:0]  len;
    logic [1:0]  nops;
    opnd_t       a;
    opnd_t       b;
    logic [15:0] fseg;
    logic        nul;
  } insn_res_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [7:0]  code_byte;
  logic        resync;
  logic [5:0]  op_group;
  logic [3:0]  op_index;
  logic [2:0]  length;
  logic [1:0]  operand_count;
  logic [2:0]  dest_kind, src_kind;
  logic [15:0] dest_value, src_value, far_segment;
  logic [7:0]  dest_attrs, src_attrs;
  logic        suspicious_null;

  insn_res_t decoded_q[$];
  int        errors = 0;
  int        send_idle = 0, recv_idle = 0;
  bit        hold_req = 0;
  bit        hold_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  // predictor state
  phase_t      pr_phase;
  logic [7:0]  pr_op, pr_mrm;
  logic [2:0]  pr_left, pr_cnt;
  logic [15:0] pr_disp, pr_imm;

  x86_16bit_instruction_decoder u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sx8(input logic [15:0] v);
    return {{8{v[7]}}, v[7:0]};
  endfunction

  function automatic bit mrm_needed(input logic [7:0] c);
    case (c[7:6])
      2'b00: return !c[2];
      2'b01: return 1'b0;
      2'b10: return c[5:4] == 2'b00;
      default:
        case (c[5:4])
          2'b00: return !c[3] && (c[2:1] == 2'b00 || c[2]);
          2'b01: return c[3] || !c[2];
          2'b10: return 1'b0;
          default: return c[2:1] == 2'b11;
        endcase
    endcase
  endfunction

  function automatic int disp_count(input logic [7:0] c, input logic [7:0] m);
    if (!mrm_needed(c)) return 0;
    if (c[7:1] == 7'h7F && m[5:3] == 3'd7) return 0;
    if (m[7:6] == 2'd1) return 1;
    if (m[7:6] == 2'd2) return 2;
    if (m[7:6] == 2'd0 && m[2:0] == 3'd6) return 2;
    return 0;
  endfunction

  function automatic int imm_count(input logic [7:0] c, input logic [7:0] m);
    case (c[7:6])
      2'b00: return (c[2:1] == 2'b10) ? (c[0] ? 2 : 1) : 0;
      2'b01: return (c[5:4] == 2'b11) ? 1 : 0;
      2'b10:
        case (c[5:4])
          2'b00: return (c[3:2] == 2'b00) ? ((c[0] && !c[1]) ? 2 : 1) : 0;
          2'b01: return (c == 8'h9A) ? 4 : 0;
          2'b10: begin
            if (c[3:2] == 2'b00) return 2;
            if (c[3:1] == 3'b100) return c[0] ? 2 : 1;
            return 0;
          end
          default: return c[3] ? 2 : 1;
        endcase
      default:
        case (c)
          8'hC0, 8'hC1, 8'hC6, 8'hCD: return 1;
          8'hC2, 8'hCA, 8'hC7: return 2;
          8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hEB: return 1;
          8'hE8, 8'hE9: return 2;
          8'hEA: return 4;
          8'hF6, 8'hF7: return (m[5:4] != 2'b00) ? 0 : (c[0] ? 2 : 1);
          default: return 0;
        endcase
    endcase
  endfunction

  function automatic opnd_t mem_or_reg(input bit w, input logic [7:0] m,
                                       input logic [15:0] dsp);
    logic [7:0]  at;
    logic [15:0] v;
    logic [7:0]  wide;
    wide = w ? A_WIDE : 8'h00;
    v = 16'h0;
    if (m[7:6] == 2'd3) return '{K_REG, {13'h0, m[2:0]}, wide};
    case (m[2:0])
      3'd0: at = A_BX | A_SI;
      3'd1: at = A_BX | A_DI;
      3'd2: at = A_BP | A_SI;
      3'd3: at = A_BP | A_DI;
      3'd4: at = A_SI;
      3'd5: at = A_DI;
      3'd6: at = A_BP;
      default: at = A_BX;
    endcase
    if (m[7:6] == 2'd0 && m[2:0] == 3'd6) begin
      v = dsp;
      at = A_DISP;
    end else if (m[7:6] == 2'd1) begin
      v = sx8(dsp);
      at |= A_DISP;
    end else if (m[7:6] == 2'd2) begin
      v = dsp;
      at |= A_DISP;
    end
    return '{K_MEM, v, at | wide};
  endfunction

  function automatic opnd_t imm_op(input bit w, input logic [15:0] v);
    return w ? opnd_t'{K_IMM, v, A_WIDE} : opnd_t'{K_IMM, {8'h0, v[7:0]}, 8'h00};
  endfunction

  function automatic opnd_t reg_op(input bit w, input logic [2:0] r);
    return '{K_REG, {13'h0, r}, w ? A_WIDE : 8'h00};
  endfunction

  function automatic insn_res_t decode_insn(input logic [7:0] c, input logic [7:0] m,
                                            input logic [15:0] dsp,
                                            input logic [15:0] imm,
                                            input logic [2:0] cnt);
    insn_res_t r;
    opnd_t     x, y, none;
    bit        w2, w1, d;
    none = '{K_NONE, 16'h0, 8'h00};
    w2 = c[0];
    w1 = c[3];
    d = c[1];
    r = '{G_INVALID, 4'd0, cnt, 2'd0, none, none, 16'h0, 1'b0};
    case (c[7:6])
      2'b00: begin
        if (!c[2]) begin
          r.grp = G_CALC2; r.idx = {1'b0, c[5:3]}; r.nops = 2'd2;
          x = reg_op(w2, m[5:3]); y = mem_or_reg(w2, m, dsp);
          if (d) begin r.a = x; r.b = y; end else begin r.a = y; r.b = x; end
          r.nul = (c[5:3] == 3'd0 && m == 8'h00);
        end else if (!c[1]) begin
          r.grp = G_CALC2; r.idx = {1'b0, c[5:3]}; r.nops = 2'd2;
          r.a = reg_op(w2, 3'd0); r.b = imm_op(w2, imm);
        end else if (!c[5]) begin
          r.grp = G_STACK1; r.idx = {3'd0, c[0]}; r.nops = 2'd1;
          r.a = '{K_SEG, {14'h0, c[4:3]}, A_WIDE};
        end else if (!c[0]) begin
          r.grp = G_SEG; r.nops = 2'd1; r.a = '{K_SEG, {14'h0, c[4:3]}, A_WIDE};
        end else begin
          r.grp = G_ADJUST1; r.idx = {2'd0, c[4:3]};
        end
      end
      2'b01: begin
        case (c[5:4])
          2'b00: begin
            r.grp = G_STEP; r.idx = {3'd0, w1}; r.nops = 2'd1; r.a = reg_op(1'b1, c[2:0]);
          end
          2'b01: begin
            r.grp = G_STACK1; r.idx = {3'd0, w1}; r.nops = 2'd1; r.a = reg_op(1'b1, c[2:0]);
          end
          2'b10: if (c[3:1] == 3'd0) begin r.grp = G_STACK2; r.idx = {3'd0, w2}; end
          default: begin
            r.grp = G_JCC; r.idx = c[3:0]; r.nops = 2'd1; r.a = '{K_LOC, sx8(imm), 8'h00};
          end
        endcase
      end
      2'b10: begin
        case (c[5:4])
          2'b00: begin
            r.nops = 2'd2;
            if (!c[2]) begin
              if (!c[3]) begin
                r.grp = G_CALC2; r.idx = {1'b0, m[5:3]}; r.a = mem_or_reg(w2, m, dsp);
                if (w2 && d) r.b = '{K_IMM, sx8(imm), A_WIDE | A_SGN};
                else r.b = imm_op(w2, imm);
              end else begin
                r.grp = G_MOV;
                x = reg_op(w2, m[5:3]); y = mem_or_reg(w2, m, dsp);
                if (d) begin r.a = x; r.b = y; end else begin r.a = y; r.b = x; end
              end
            end else if (!c[3]) begin
              r.grp = c[1] ? G_XCHG : G_TEST;
              r.a = reg_op(w2, m[5:3]); r.b = mem_or_reg(w2, m, dsp);
            end else if (!c[0]) begin
              r.grp = G_MOV;
              x = '{K_SEG, {14'h0, m[4:3]}, A_WIDE}; y = mem_or_reg(1'b1, m, dsp);
              if (d) begin r.a = x; r.b = y; end else begin r.a = y; r.b = x; end
            end else if (!c[1]) begin
              r.grp = G_LEA; r.a = reg_op(1'b1, m[5:3]); r.b = mem_or_reg(1'b1, m, dsp);
            end else begin
              r.grp = G_POP; r.nops = 2'd1; r.a = mem_or_reg(1'b1, m, dsp);
            end
          end
          2'b01: begin
            if (!c[3]) begin
              if (c == 8'h90) r.grp = G_NOP;
              else begin
                r.grp = G_XCHG; r.nops = 2'd2;
                r.a = reg_op(1'b1, 3'd0); r.b = reg_op(1'b1, c[2:0]);
              end
            end else begin
              case (c[2:0])
                3'd0, 3'd1: begin r.grp = G_CONVERT; r.idx = {3'd0, w2}; end
                3'd2: begin
                  r.grp = G_CALLF; r.nops = 2'd1; r.a = '{K_LOC, imm, A_FAR}; r.fseg = dsp;
                end
                3'd3: r.grp = G_WAIT;
                3'd4, 3'd5: begin r.grp = G_STACK3; r.idx = {3'd0, w2}; end
                default: begin r.grp = G_FLAGS1; r.idx = {3'd0, w2}; end
              endcase
            end
          end
          2'b10: begin
            if (c[3:2] == 2'b00) begin
              r.grp = G_MOV; r.nops = 2'd2;
              x = reg_op(w2, 3'd0);
              y = '{K_MEM, imm, A_DISP | (w2 ? A_WIDE : 8'h00)};
              if (d) begin r.a = y; r.b = x; end else begin r.a = x; r.b = y; end
            end else if (c[3:1] == 3'b100) begin
              r.grp = G_TEST; r.nops = 2'd2; r.a = reg_op(w2, 3'd0); r.b = imm_op(w2, imm);
            end else begin
              r.grp = G_STRING; r.idx = {1'b0, c[3:1]};
            end
          end
          default: begin
            r.grp = G_MOV; r.nops = 2'd2; r.a = reg_op(w1, c[2:0]); r.b = imm_op(w1, imm);
          end
        endcase
      end
      default: begin
        case (c[5:4])
          2'b00: begin
            if (!c[3]) begin
              if (!c[2]) begin
                if (!c[1]) begin
                  r.grp = G_BITS; r.idx = {1'b0, m[5:3]}; r.nops = 2'd2;
                  r.a = mem_or_reg(w2, m, dsp); r.b = imm_op(1'b0, imm);
                end else begin
                  r.grp = G_RET;
                  if (!c[0]) begin r.nops = 2'd1; r.a = imm_op(1'b1, imm); end
                end
              end else if (!c[1]) begin
                r.grp = G_LOAD; r.idx = {3'd0, w2}; r.nops = 2'd2;
                r.a = reg_op(1'b1, m[5:3]);
                r.b = mem_or_reg(1'b1, m, dsp); r.b.attrs |= A_FAR;
              end else begin
                r.grp = G_MOV; r.nops = 2'd2;
                r.a = mem_or_reg(w2, m, dsp); r.b = imm_op(w2, imm);
              end
            end else if (!c[2]) begin
              if (c[1]) begin
                r.grp = G_RETF;
                if (!c[0]) begin r.nops = 2'd1; r.a = imm_op(1'b1, imm); end
              end
            end else begin
              r.grp = G_INTS; r.idx = {2'd0, c[1:0]};
              if (c[1:0] == 2'd1) begin r.nops = 2'd1; r.a = imm_op(1'b0, imm); end
            end
          end
          2'b01: begin
            if (!c[3]) begin
              if (!c[2]) begin
                r.grp = G_BITS; r.idx = {1'b0, m[5:3]}; r.nops = 2'd2;
                r.a = mem_or_reg(w2, m, dsp);
                r.b = d ? opnd_t'{K_REG, 16'd1, 8'h00} : opnd_t'{K_IMM, 16'd1, 8'h00};
              end else begin
                r.grp = c[1] ? G_MISC : G_ADJUST2; r.idx = {3'd0, w2};
              end
            end else begin
              r.grp = G_ESC; r.nops = 2'd1; r.a = mem_or_reg(1'b1, m, dsp);
            end
          end
          2'b10: begin
            r.nops = 2'd1;
            if (!c[2]) begin
              if (!c[3]) begin
                r.grp = G_LOOP; r.idx = {2'd0, c[1:0]}; r.a = '{K_LOC, sx8(imm), 8'h00};
              end else if (!c[1]) begin
                r.grp = G_FLOW; r.idx = {3'd0, w2}; r.a = '{K_LOC, imm, 8'h00};
              end else if (!c[0]) begin
                r.grp = G_JMPF; r.a = '{K_LOC, imm, A_FAR}; r.fseg = dsp;
              end else begin
                r.grp = G_JMP; r.a = '{K_LOC, sx8(imm), 8'h00};
              end
            end else begin
              r.grp = G_PORT; r.idx = {3'd0, d}; r.nops = 2'd2;
              x = reg_op(w2, 3'd0);
              y = w1 ? reg_op(1'b1, 3'd2) : opnd_t'{K_IMM, {8'h0, imm[7:0]}, A_WIDE};
              if (d) begin r.a = y; r.b = x; end else begin r.a = x; r.b = y; end
            end
          end
          default: begin
            if (!c[3]) begin
              if (c[2:1] != 2'b11) begin
                if (c != 8'hF1) begin r.grp = G_PREFIX; r.idx = {1'b0, c[2:0]}; end
              end else if (m[5:4] == 2'b00) begin
                r.grp = G_TEST; r.nops = 2'd2;
                r.a = mem_or_reg(w2, m, dsp); r.b = imm_op(w2, imm);
              end else begin
                r.grp = G_CALC1; r.idx = {1'b0, m[5:3]}; r.nops = 2'd1;
                r.a = mem_or_reg(w2, m, dsp);
              end
            end else if (c[2:1] != 2'b11) begin
              r.grp = G_FLAGS2; r.idx = {1'b0, c[2:0]};
            end else begin
              r.nops = 2'd1;
              r.a = mem_or_reg(1'b1, m, dsp);
              case (m[5:3])
                3'd0, 3'd1: begin
                  r.grp = G_INC; r.idx = {1'b0, m[5:3]}; r.a = mem_or_reg(w2, m, dsp);
                end
                3'd2: r.grp = G_CALL;
                3'd3: begin r.grp = G_CALLF; r.a.attrs |= A_FAR; end
                3'd4: r.grp = G_JMP;
                3'd5: begin r.grp = G_JMPF; r.a.attrs |= A_FAR; end
                3'd6: r.grp = G_PUSH;
                default: begin r.nops = 2'd0; r.a = none; end
              endcase
            end
          end
        endcase
      end
    endcase
    return r;
  endfunction

  // Advance the predictor by one accepted byte; queue a result when complete.
  task automatic predict_byte(input logic [7:0] cb, input logic rs);
    int dl, il, k, first;
    if (rs || pr_phase == PH_OPCODE) begin
      pr_op = cb; pr_mrm = 8'h0; pr_disp = 16'h0; pr_imm = 16'h0;
      pr_cnt = 3'd1; pr_left = 3'd0;
      if (mrm_needed(cb)) begin pr_phase = PH_MODRM; return; end
    end else if (pr_phase == PH_MODRM) begin
      pr_mrm = cb;
      pr_cnt = pr_cnt + 3'd1;
      dl = disp_count(pr_op, pr_mrm);
      if (dl != 0) begin pr_phase = PH_DISP; pr_left = dl[2:0]; return; end
    end else if (pr_phase == PH_DISP) begin
      k = (pr_cnt - 3'd2) & 1;
      pr_disp |= 16'(cb) << (8 * k);
      pr_cnt = pr_cnt + 3'd1;
      if (pr_left != 0) pr_left--;
      if (pr_left != 0) return;
    end else begin
      first = 1 + int'(mrm_needed(pr_op)) + disp_count(pr_op, pr_mrm);
      k = (int'(pr_cnt) - first) & 3;
      if (k < 2) pr_imm |= 16'(cb) << (8 * k);
      else pr_disp |= 16'(cb) << (8 * (k - 2));
      pr_cnt = pr_cnt + 3'd1;
      if (pr_left != 0) pr_left--;
      if (pr_left != 0) return;
      pr_phase = PH_OPCODE;
      decoded_q.push_back(decode_insn(pr_op, pr_mrm, pr_disp, pr_imm, pr_cnt));
      return;
    end
    il = imm_count(pr_op, pr_mrm);
    if (il != 0) begin pr_phase = PH_IMM; pr_left = il[2:0]; return; end
    pr_phase = PH_OPCODE;
    decoded_q.push_back(decode_insn(pr_op, pr_mrm, pr_disp, pr_imm, pr_cnt));
  endtask

  // Offer one code byte; hold it until taken.
  task automatic send_byte(input logic [7:0] cb, input logic rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= cb;
    resync <= rs;
    do @(posedge clk); while (in_stall);
    predict_byte(cb, rs);
  endtask

  // Send one instruction with random operand bytes, optionally cut short.
  task automatic send_insn(input logic [7:0] op, input logic rs, input int cut);
    logic [7:0] m;
    int total;
    m = 8'($urandom_range(255));
    total = 1 + int'(mrm_needed(op));
    total += disp_count(op, m) + imm_count(op, m);
    send_byte(op, rs);
    for (int i = 1; i < total && i < cut; i++)
      send_byte((i == 1 && mrm_needed(op)) ? m : 8'($urandom_range(255)),
                $urandom_range(99) < 3);
  endtask

  // Drop valid so the last word is not taken again, then let results drain.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    insn_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t unexpected word: expected none actual group %h", $time, op_group);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        check_field("op_group", 16'(e.grp), 16'(op_group));
        check_field("op_index", 16'(e.idx), 16'(op_index));
        check_field("length", 16'(e.len), 16'(length));
        check_field("operand_count", 16'(e.nops), 16'(operand_count));
        check_field("dest_kind", 16'(e.a.kind), 16'(dest_kind));
        check_field("dest_value", e.a.value, dest_value);
        check_field("dest_attrs", 16'(e.a.attrs), 16'(dest_attrs));
        check_field("src_kind", 16'(e.b.kind), 16'(src_kind));
        check_field("src_value", e.b.value, src_value);
        check_field("src_attrs", 16'(e.b.attrs), 16'(src_attrs));
        check_field("far_segment", e.fseg, far_segment);
        check_field("suspicious_null", 16'(e.nul), 16'(suspicious_null));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    logic [7:0] seq[$];
    // all bytes go without resync, opcodes and operand bytes alike
    seq = '{8'h00, 8'h00, 8'h03, 8'hC1, 8'h05, 8'h34, 8'h12,
            8'h81, 8'h80, 8'h78, 8'h56, 8'h34, 8'h12, 8'h83, 8'hC3, 8'hF0,
            8'h9A, 8'h11, 8'h22, 8'h33, 8'h44, 8'hEA, 8'h01, 8'h02, 8'h03, 8'h04,
            8'hF6, 8'h06, 8'h10, 8'h20, 8'h55, 8'hF7, 8'hD8, 8'hFF, 8'hF8,
            8'hFE, 8'h3E, 8'h62, 8'h6F, 8'hC8, 8'hC9, 8'hF1, 8'hF0, 8'h8C, 8'hD8,
            8'h8E, 8'h5E, 8'h08, 8'hA1, 8'h00, 8'h80, 8'hA2, 8'hFF, 8'hFF,
            8'hC0, 8'hE0, 8'h03, 8'hE4, 8'h60, 8'hEF, 8'hD3, 8'hE0, 8'h70, 8'hFE,
            8'hE8, 8'hFF, 8'h7F, 8'hCD, 8'h21, 8'hFF, 8'h1E, 8'h34, 8'h12,
            8'h82, 8'h47, 8'h80, 8'h7F, 8'h8F, 8'hE0, 8'h60, 8'h61, 8'h90};
    foreach (seq[i]) send_byte(seq[i], 1'b0);
    // abandon a partial instruction
    send_byte(8'h81, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_random(input int nbytes, input int s_idle, input int r_idle);
    logic rs;
    send_idle = s_idle;
    recv_idle = r_idle;
    rs = 1'b1;
    for (int sent = 0; sent < nbytes; sent += 3) begin
      if ($urandom_range(99) < 4) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if ($urandom_range(99) < 8) begin
        send_insn(8'($urandom_range(255)), rs, $urandom_range(1, 3));
        rs = 1'b1;
        continue;
      end else begin
        send_insn(8'($urandom_range(255)), rs ? 1'b1 : 1'($urandom_range(1)), 7);
      end
      rs = 1'b0;
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_req = !hold_req;
    for (int i = 0; i < 30; i++) send_insn(8'($urandom_range(255)), 1'b1, 7);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    code_byte = 8'h00;
    resync = 1'b0;
    pr_phase = PH_OPCODE;
    pr_op = 8'h0; pr_mrm = 8'h0; pr_left = 3'd0; pr_cnt = 3'd0;
    pr_disp = 16'h0; pr_imm = 16'h0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 17, 61);
    test_random(300, 61, 17);
    test_random(300, 0, 0);
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
